// File: sv/prv_pkg.sv
package prv_pkg;

    localparam int MAX_LENGTH_DEF = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam logic MODE_CLAMP  = 1'b0;
    localparam logic MODE_REVERT = 1'b1;

    localparam logic KIND_SPREAD = 1'b0;
    localparam logic KIND_ROW    = 1'b1;

    typedef struct packed {
        logic repl;
        logic in_range;
        logic diag_take;
    } check_flags_t;

endpackage

// File: sv/prv_check.sv
module prv_check #(
    parameter int VALUE_BITS = prv_pkg::VALUE_BITS_DEF
) (
    input  logic                         repair_mode,
    input  logic                         kind,
    input  logic signed [VALUE_BITS-1:0] new_value,
    input  logic signed [VALUE_BITS-1:0] lower_bound,
    input  logic signed [VALUE_BITS-1:0] upper_bound,
    input  logic signed [VALUE_BITS-1:0] previous_value,
    input  logic                         is_diagonal,
    output logic signed [VALUE_BITS-1:0] value,
    output logic signed [VALUE_BITS:0]   diff,
    output prv_pkg::check_flags_t        flags
);

    logic                         below;
    logic                         above;
    logic                         take;
    logic                         repl;
    logic signed [VALUE_BITS-1:0] target;

    always_comb
    begin
        take   = (kind == prv_pkg::KIND_ROW) && is_diagonal;
        below  = new_value < lower_bound;
        above  = new_value > upper_bound;
        repl   = !take && (below || above);
        if (repair_mode == prv_pkg::MODE_REVERT)
        begin
            target = previous_value;
        end
        else if (below)
        begin
            target = lower_bound;
        end
        else
        begin
            target = upper_bound;
        end
        value = repl ? target : new_value;
        if (repl)
        begin
            diff = {new_value[VALUE_BITS-1], new_value} - {target[VALUE_BITS-1], target};
        end
        else
        begin
            diff = '0;
        end
        flags.repl      = repl;
        flags.in_range  = !take && !repl;
        flags.diag_take = take;
    end

endmodule

// File: sv/prv_divider.sv
module prv_divider #(
    parameter int DW = prv_pkg::VALUE_BITS_DEF + 8,
    parameter int VW = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [DW-1:0] dividend,
    input  logic        [VW-1:0] divisor,
    output logic signed [DW-1:0] quotient,
    output logic                 done
);

    localparam int NW = $clog2(DW + 1);

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_FIX
    } div_state_t;

    div_state_t          state_reg, state_next;
    logic [NW-1:0]       cnt_reg, cnt_next;
    logic [VW-1:0]       rem_reg, rem_next;
    logic [DW-1:0]       quo_reg, quo_next;
    logic [VW-1:0]       div_reg, div_next;
    logic                neg_reg, neg_next;
    logic signed [DW-1:0] quotient_reg, quotient_next;
    logic                done_reg, done_next;
    logic [VW:0]         rem_sh;
    logic                fits;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        div_next      = div_reg;
        neg_next      = neg_reg;
        quotient_next = quotient_reg;
        done_next     = 1'b0;
        rem_sh        = {rem_reg, quo_reg[DW-1]};
        fits          = rem_sh >= {1'b0, div_reg};
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    neg_next   = dividend[DW-1];
                    quo_next   = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
                    rem_next   = '0;
                    div_next   = divisor;
                    cnt_next   = NW'(DW);
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                if (fits)
                begin
                    rem_next = VW'(rem_sh - {1'b0, div_reg});
                end
                else
                begin
                    rem_next = rem_sh[VW-1:0];
                end
                quo_next = {quo_reg[DW-2:0], fits};
                cnt_next = cnt_reg - NW'(1);
                if (cnt_reg == NW'(1))
                begin
                    state_next = D_FIX;
                end
            end
            D_FIX:
            begin
                quotient_next = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
                done_next     = 1'b1;
                state_next    = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        div_reg      <= div_next;
        neg_reg      <= neg_next;
        quotient_reg <= quotient_next;
    end

    assign quotient = quotient_reg;
    assign done     = done_reg;

endmodule

// File: sv/probability_vector_bound_repair_top.sv
// Bound repair for one probability vector. Elements are taken one per cycle
// (start high, busy low) and checked against their bounds as they arrive; the
// element marked last, or the one that fills MAX_LENGTH entries, closes the
// vector and raises busy. A decision state follows. A spread vector with
// replaced elements and at least one in-range element then runs the restoring
// divider, one quotient bit per cycle. The n repaired elements leave in arrival
// order, one per cycle, through a registered buffer read and a saturating adder
// with a registered output; busy falls once the last buffer read is issued.
// Each result beat is shown for exactly one cycle on result_valid and cannot be
// stalled: the receiver must take it at once.
module probability_vector_bound_repair_top #(
    parameter int MAX_LENGTH = prv_pkg::MAX_LENGTH_DEF,
    parameter int VALUE_BITS = prv_pkg::VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_data,
    input  logic                         start,
    output logic                         busy,
    input  logic                         command,
    input  logic signed [VALUE_BITS-1:0] new_value,
    input  logic signed [VALUE_BITS-1:0] lower_bound,
    input  logic signed [VALUE_BITS-1:0] upper_bound,
    input  logic signed [VALUE_BITS-1:0] previous_value,
    input  logic                         is_diagonal,
    input  logic                         last,
    output logic                         result_valid,
    output logic signed [VALUE_BITS-1:0] corrected_value,
    output logic                         was_replaced,
    output logic                         status,
    output logic                         last_out
);

    localparam int AW = $clog2(MAX_LENGTH);
    localparam int CW = $clog2(MAX_LENGTH + 1);
    localparam int EW = VALUE_BITS + 8;
    localparam int SW = EW + 1;
    localparam logic signed [SW-1:0] SAT_HI =
        {{(SW-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO =
        {{(SW-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_DECIDE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic                 mode_reg, mode_next;
    logic                 kind_reg, kind_next;
    logic [CW-1:0]        elem_cnt_reg, elem_cnt_next;
    logic [CW-1:0]        in_range_reg, in_range_next;
    logic signed [EW-1:0] excess_reg, excess_next;
    logic                 diag_seen_reg, diag_seen_next;
    logic [AW-1:0]        diag_pos_reg, diag_pos_next;
    logic                 any_repl_reg, any_repl_next;
    logic [CW-1:0]        count_reg, count_next;
    logic signed [EW-1:0] emit_add_reg, emit_add_next;
    logic                 emit_en_reg, emit_en_next;
    logic                 emit_spread_reg, emit_spread_next;
    logic [AW-1:0]        emit_diag_reg, emit_diag_next;
    logic                 status_reg, status_next;
    logic [CW-1:0]        rd_idx_reg, rd_idx_next;
    logic                 p1_valid_reg, p1_valid_next;
    logic                 p1_last_reg, p1_last_next;
    logic                 p1_diag_reg, p1_diag_next;
    logic                 result_valid_reg, result_valid_next;
    logic signed [VALUE_BITS-1:0] corrected_reg, corrected_next;
    logic                 replaced_reg, replaced_next;
    logic                 out_status_reg, out_status_next;
    logic                 last_out_reg, last_out_next;

    logic signed [VALUE_BITS-1:0] value_mem [MAX_LENGTH];
    logic                         repl_mem  [MAX_LENGTH];
    logic signed [VALUE_BITS-1:0] rd_value_reg;
    logic                         rd_repl_reg;

    logic                         accept;
    logic                         first;
    logic                         kind_eff;
    logic                         close;
    logic signed [VALUE_BITS-1:0] chk_value;
    logic signed [VALUE_BITS:0]   chk_diff;
    prv_pkg::check_flags_t        chk_flags;
    logic                         div_start;
    logic signed [EW-1:0]         div_quotient;
    logic                         div_done;
    logic                         spread;
    logic                         take;
    logic signed [SW-1:0]         sum;

    assign accept   = start && (state_reg == ST_COLLECT);
    assign first    = elem_cnt_reg == '0;
    assign kind_eff = first ? command : kind_reg;
    assign close    = last || (elem_cnt_reg == CW'(MAX_LENGTH - 1));
    assign spread   = kind_reg == prv_pkg::KIND_SPREAD;

    prv_check #(
        .VALUE_BITS(VALUE_BITS)
    ) u_check (
        .repair_mode   (mode_reg),
        .kind          (kind_eff),
        .new_value     (new_value),
        .lower_bound   (lower_bound),
        .upper_bound   (upper_bound),
        .previous_value(previous_value),
        .is_diagonal   (is_diagonal),
        .value         (chk_value),
        .diff          (chk_diff),
        .flags         (chk_flags)
    );

    prv_divider #(
        .DW(EW),
        .VW(CW)
    ) u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(excess_reg),
        .divisor (in_range_reg),
        .quotient(div_quotient),
        .done    (div_done)
    );

    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        kind_next        = kind_reg;
        elem_cnt_next    = elem_cnt_reg;
        in_range_next    = in_range_reg;
        excess_next      = excess_reg;
        diag_seen_next   = diag_seen_reg;
        diag_pos_next    = diag_pos_reg;
        any_repl_next    = any_repl_reg;
        count_next       = count_reg;
        emit_add_next    = emit_add_reg;
        emit_en_next     = emit_en_reg;
        emit_spread_next = emit_spread_reg;
        emit_diag_next   = emit_diag_reg;
        status_next      = status_reg;
        rd_idx_next      = rd_idx_reg;
        p1_valid_next    = 1'b0;
        p1_last_next     = 1'b0;
        p1_diag_next     = 1'b0;
        div_start        = 1'b0;

        if (cfg_valid)
        begin
            mode_next = cfg_data;
        end

        case (state_reg)
            ST_COLLECT:
            begin
                if (accept)
                begin
                    kind_next      = kind_eff;
                    excess_next    = (first ? '0 : excess_reg)
                                   + {{(EW-VALUE_BITS-1){chk_diff[VALUE_BITS]}}, chk_diff};
                    in_range_next  = (first ? '0 : in_range_reg)
                                   + CW'(chk_flags.in_range);
                    diag_seen_next = (first ? 1'b0 : diag_seen_reg) | chk_flags.diag_take;
                    if (chk_flags.diag_take)
                    begin
                        diag_pos_next = elem_cnt_reg[AW-1:0];
                    end
                    else if (first)
                    begin
                        diag_pos_next = '0;
                    end
                    any_repl_next  = (first ? 1'b0 : any_repl_reg) | chk_flags.repl;
                    if (close)
                    begin
                        count_next    = elem_cnt_reg + CW'(1);
                        elem_cnt_next = '0;
                        state_next    = ST_DECIDE;
                    end
                    else
                    begin
                        elem_cnt_next = elem_cnt_reg + CW'(1);
                    end
                end
            end
            ST_DECIDE:
            begin
                if (spread)
                begin
                    emit_en_next = any_repl_reg && (in_range_reg != '0);
                    status_next  = any_repl_reg && (in_range_reg == '0);
                end
                else
                begin
                    emit_en_next = (excess_reg != '0) && diag_seen_reg;
                    status_next  = (excess_reg != '0) && !diag_seen_reg;
                end
                emit_spread_next = spread;
                emit_diag_next   = diag_pos_reg;
                emit_add_next    = excess_reg;
                rd_idx_next      = '0;
                if (spread && any_repl_reg && (in_range_reg != '0))
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    emit_add_next = div_quotient;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                p1_valid_next = 1'b1;
                p1_last_next  = rd_idx_reg == (count_reg - CW'(1));
                p1_diag_next  = rd_idx_reg[AW-1:0] == emit_diag_reg;
                rd_idx_next   = rd_idx_reg + CW'(1);
                if (p1_last_next)
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // add the share or the row excess, then saturate
    always_comb
    begin
        take = emit_en_reg && (emit_spread_reg ? !rd_repl_reg : p1_diag_reg);
        sum  = {{(SW-VALUE_BITS){rd_value_reg[VALUE_BITS-1]}}, rd_value_reg}
             + (take ? {emit_add_reg[EW-1], emit_add_reg} : SW'(0));
        if (sum > SAT_HI)
        begin
            corrected_next = SAT_HI[VALUE_BITS-1:0];
        end
        else if (sum < SAT_LO)
        begin
            corrected_next = SAT_LO[VALUE_BITS-1:0];
        end
        else
        begin
            corrected_next = sum[VALUE_BITS-1:0];
        end
        result_valid_next = p1_valid_reg;
        replaced_next     = rd_repl_reg;
        out_status_next   = status_reg;
        last_out_next     = p1_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_COLLECT;
            mode_reg         <= prv_pkg::MODE_CLAMP;
            kind_reg         <= prv_pkg::KIND_SPREAD;
            elem_cnt_reg     <= '0;
            in_range_reg     <= '0;
            excess_reg       <= '0;
            diag_seen_reg    <= 1'b0;
            diag_pos_reg     <= '0;
            any_repl_reg     <= 1'b0;
            count_reg        <= '0;
            emit_en_reg      <= 1'b0;
            emit_spread_reg  <= 1'b0;
            emit_diag_reg    <= '0;
            status_reg       <= 1'b0;
            rd_idx_reg       <= '0;
            p1_valid_reg     <= 1'b0;
            p1_last_reg      <= 1'b0;
            p1_diag_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            mode_reg         <= mode_next;
            kind_reg         <= kind_next;
            elem_cnt_reg     <= elem_cnt_next;
            in_range_reg     <= in_range_next;
            excess_reg       <= excess_next;
            diag_seen_reg    <= diag_seen_next;
            diag_pos_reg     <= diag_pos_next;
            any_repl_reg     <= any_repl_next;
            count_reg        <= count_next;
            emit_en_reg      <= emit_en_next;
            emit_spread_reg  <= emit_spread_next;
            emit_diag_reg    <= emit_diag_next;
            status_reg       <= status_next;
            rd_idx_reg       <= rd_idx_next;
            p1_valid_reg     <= p1_valid_next;
            p1_last_reg      <= p1_last_next;
            p1_diag_reg      <= p1_diag_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        emit_add_reg   <= emit_add_next;
        corrected_reg  <= corrected_next;
        replaced_reg   <= replaced_next;
        out_status_reg <= out_status_next;
        last_out_reg   <= last_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_mem[elem_cnt_reg[AW-1:0]] <= chk_value;
            repl_mem[elem_cnt_reg[AW-1:0]]  <= chk_flags.repl;
        end
        rd_value_reg <= value_mem[rd_idx_reg[AW-1:0]];
        rd_repl_reg  <= repl_mem[rd_idx_reg[AW-1:0]];
    end

    assign cfg_ready       = 1'b1;
    assign busy            = state_reg != ST_COLLECT;
    assign result_valid    = result_valid_reg;
    assign corrected_value = corrected_reg;
    assign was_replaced    = replaced_reg;
    assign status          = out_status_reg;
    assign last_out        = last_out_reg;

endmodule

// File: bench/tb_probability_vector_bound_repair_top.sv
module tb_probability_vector_bound_repair_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   VB          = prv_pkg::VALUE_BITS_DEF;
    localparam int   ML          = prv_pkg::MAX_LENGTH_DEF;
    localparam logic KIND_SPREAD = prv_pkg::KIND_SPREAD;
    localparam logic KIND_ROW    = prv_pkg::KIND_ROW;
    localparam logic MODE_CLAMP  = prv_pkg::MODE_CLAMP;
    localparam logic MODE_REVERT = prv_pkg::MODE_REVERT;
    localparam int   VMAX        = 32'h7fff_ffff;
    localparam int   VMIN        = -2147483647 - 1;

    typedef struct packed {
        logic                 command;
        logic signed [VB-1:0] new_value;
        logic signed [VB-1:0] lower_bound;
        logic signed [VB-1:0] upper_bound;
        logic signed [VB-1:0] previous_value;
        logic                 is_diagonal;
        logic                 last;
    } element_t;

    typedef struct packed {
        logic signed [VB-1:0] corrected;
        logic                 replaced;
        logic                 stat;
        logic                 is_last;
    } beat_t;

    typedef struct packed {
        element_t el;
        logic     mode;
        logic     typed;
        beat_t    want;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_data;
    logic                 start;
    logic                 busy;
    logic                 command;
    logic signed [VB-1:0] new_value;
    logic signed [VB-1:0] lower_bound;
    logic signed [VB-1:0] upper_bound;
    logic signed [VB-1:0] previous_value;
    logic                 is_diagonal;
    logic                 last;
    logic                 result_valid;
    logic signed [VB-1:0] corrected_value;
    logic                 was_replaced;
    logic                 status;
    logic                 last_out;

    probability_vector_bound_repair_top #(
        .MAX_LENGTH(ML),
        .VALUE_BITS(VB)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .new_value      (new_value),
        .lower_bound    (lower_bound),
        .upper_bound    (upper_bound),
        .previous_value (previous_value),
        .is_diagonal    (is_diagonal),
        .last           (last),
        .result_valid   (result_valid),
        .corrected_value(corrected_value),
        .was_replaced   (was_replaced),
        .status         (status),
        .last_out       (last_out)
    );

    // repair state mirrored from the block
    logic                 repair_mode_q;
    logic signed [VB-1:0] vec_value [ML];
    bit                   vec_repl [ML];
    longint               vec_excess;
    int                   vec_in_range;
    int                   vec_count;
    int                   vec_diag_pos;
    logic                 vec_kind;
    bit                   vec_diag_seen;

    beat_t pending_beats[$];
    row_t  dir_rows[$];
    int    mismatches;
    int    beats_seen;
    int    items_sent;
    int    vectors_closed;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic signed [VB-1:0] sat_value(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (VB - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            v = hi;
        else if (v < lo)
            v = lo;
        return v[VB-1:0];
    endfunction

    function automatic void clear_vector();
        vec_excess    = 0;
        vec_in_range  = 0;
        vec_count     = 0;
        vec_diag_pos  = 0;
        vec_diag_seen = 0;
    endfunction

    function automatic void repair_element(element_t e, logic typed, beat_t want);
        int                   pos;
        int                   n;
        int                   k;
        longint               nv;
        longint               lb;
        longint               ub;
        longint               pv;
        longint               share;
        logic signed [VB-1:0] val;
        bit                   repl;
        bit                   stat;
        bit                   any;
        beat_t                b;
        pos   = vec_count;
        nv    = e.new_value;
        lb    = e.lower_bound;
        ub    = e.upper_bound;
        pv    = e.previous_value;
        val   = e.new_value;
        repl  = 0;
        stat  = 0;
        any   = 0;
        share = 0;
        if (pos >= ML)
        begin
            clear_vector();
            pos = 0;
        end
        if (pos == 0)
        begin
            clear_vector();
            vec_kind = e.command;
        end
        if (vec_kind == KIND_ROW && e.is_diagonal)
        begin
            vec_diag_seen = 1;
            vec_diag_pos  = pos;
        end
        else if (nv < lb || nv > ub)
        begin
            repl = 1;
            if (repair_mode_q == MODE_REVERT)
            begin
                vec_excess += nv - pv;
                val = e.previous_value;
            end
            else if (nv < lb)
            begin
                vec_excess += nv - lb;
                val = e.lower_bound;
            end
            else
            begin
                vec_excess += nv - ub;
                val = e.upper_bound;
            end
        end
        else
            vec_in_range++;
        vec_value[pos] = val;
        vec_repl[pos]  = repl;
        vec_count      = pos + 1;
        if (!e.last && vec_count < ML)
            return;

        n = vec_count;
        if (vec_kind == KIND_SPREAD)
        begin
            for (k = 0; k < n; k++)
                if (vec_repl[k])
                    any = 1;
            if (any)
            begin
                if (vec_in_range == 0)
                    stat = 1;
                else
                    share = vec_excess / longint'(vec_in_range);
            end
            if (any && !stat)
                for (k = 0; k < n; k++)
                    if (!vec_repl[k])
                        vec_value[k] = sat_value(longint'(vec_value[k]) + share);
        end
        else if (vec_excess != 0)
        begin
            if (vec_diag_seen)
                vec_value[vec_diag_pos] =
                    sat_value(longint'(vec_value[vec_diag_pos]) + vec_excess);
            else
                stat = 1;
        end

        if (typed && n == 1)
            pending_beats.push_back(want);
        else
            for (k = 0; k < n; k++)
            begin
                b.corrected = vec_value[k];
                b.replaced  = vec_repl[k];
                b.stat      = stat;
                b.is_last   = (k + 1 == n);
                pending_beats.push_back(b);
            end
        vectors_closed++;
        clear_vector();
    endfunction

    function automatic void add_row(logic cmd, int nv, int lb, int ub, int pv, logic diag,
                                    logic lst, logic mode, logic typed, int wv, logic wr,
                                    logic ws);
        row_t r;
        r.el.command        = cmd;
        r.el.new_value      = nv;
        r.el.lower_bound    = lb;
        r.el.upper_bound    = ub;
        r.el.previous_value = pv;
        r.el.is_diagonal    = diag;
        r.el.last           = lst;
        r.mode              = mode;
        r.typed             = typed;
        r.want.corrected    = wv;
        r.want.replaced     = wr;
        r.want.stat         = ws;
        r.want.is_last      = 1'b1;
        dir_rows.push_back(r);
    endfunction

    function automatic element_t rand_element();
        element_t    e;
        int unsigned lo;
        int unsigned span;
        int unsigned nv;
        if ($urandom_range(9) < 2)
        begin
            e.new_value      = $urandom;
            e.lower_bound    = $urandom;
            e.upper_bound    = $urandom;
            e.previous_value = $urandom;
        end
        else
        begin
            lo   = $urandom_range(32'h3000_0000);
            span = $urandom_range(32'h1000_0000);
            case ($urandom_range(4))
                0:       nv = lo - $urandom_range(32'h1000_0000, 1);
                1:       nv = lo + span + $urandom_range(32'h1000_0000, 1);
                default: nv = lo + $urandom_range(span);
            endcase
            e.new_value      = nv;
            e.lower_bound    = lo;
            e.upper_bound    = lo + span;
            e.previous_value = ($urandom_range(3) == 0) ? $urandom : lo + $urandom_range(span);
        end
        e.command     = 1'b0;
        e.is_diagonal = 1'b0;
        e.last        = 1'b0;
        return e;
    endfunction

    task automatic write_mode(logic m);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid     <= 1'b0;
        repair_mode_q  = m;
    endtask

    task automatic send_item(element_t e, int idle_pct, logic typed, beat_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start          <= 1'b1;
        command        <= e.command;
        new_value      <= e.new_value;
        lower_bound    <= e.lower_bound;
        upper_bound    <= e.upper_bound;
        previous_value <= e.previous_value;
        is_diagonal    <= e.is_diagonal;
        last           <= e.last;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        repair_element(e, typed, want);
    endtask

    task automatic send_vector(int len, bit full, int idle_pct);
        element_t e;
        logic     kind;
        int       diag_a;
        int       diag_b;
        int       r;
        int       k;
        kind   = 1'($urandom_range(1));
        r      = $urandom_range(19);
        diag_a = (r < 2) ? -1 : $urandom_range(len - 1);
        diag_b = (r >= 17) ? $urandom_range(len - 1) : -1;
        for (k = 0; k < len; k++)
        begin
            e             = rand_element();
            e.command     = (k == 0) ? kind : 1'($urandom_range(1));
            e.is_diagonal = (kind == KIND_ROW) ? (k == diag_a || k == diag_b)
                                               : 1'($urandom_range(1));
            e.last        = (k == len - 1) && !full;
            send_item(e, idle_pct, 1'b0, '0);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : check_beats
        beat_t want;
        beat_t got;
        if (rst_n && result_valid)
        begin
            beats_seen++;
            got = {corrected_value, was_replaced, status, last_out};
            if (pending_beats.size() == 0)
            begin
                if (mismatches < 10)
                    $display("beat %0d unexpected: value %h repl %b status %b last %b",
                             beats_seen, got.corrected, got.replaced, got.stat, got.is_last);
                mismatches++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (got.corrected !== want.corrected || got.replaced !== want.replaced ||
                    got.stat !== want.stat || got.is_last !== want.is_last)
                begin
                    if (mismatches < 10)
                        $display({"beat %0d: got value %h repl %b status %b last %b, ",
                                  "want %h %b %b %b"},
                                 beats_seen, got.corrected, got.replaced, got.stat, got.is_last,
                                 want.corrected, want.replaced, want.stat, want.is_last);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : main
        int phase;
        int pct;
        int phase_items;
        int i;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = 1'b0;
        start          = 1'b0;
        command        = 1'b0;
        new_value      = '0;
        lower_bound    = '0;
        upper_bound    = '0;
        previous_value = '0;
        is_diagonal    = 1'b0;
        last           = 1'b0;
        mismatches     = 0;
        beats_seen     = 0;
        items_sent     = 0;
        vectors_closed = 0;
        repair_mode_q  = MODE_CLAMP;
        vec_kind       = KIND_SPREAD;
        clear_vector();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_mode(MODE_CLAMP);

        // single-element vectors with the answer typed in
        add_row(KIND_SPREAD, 0, -1, 1, 0, 0, 1, MODE_CLAMP, 1, 0, 0, 0);
        add_row(KIND_SPREAD, VMAX, 0, 100, 0, 0, 1, MODE_CLAMP, 1, 100, 1, 1);
        add_row(KIND_SPREAD, VMIN, -5, 5, 0, 0, 1, MODE_CLAMP, 1, -5, 1, 1);
        add_row(KIND_SPREAD, 0, 10, -10, 0, 0, 1, MODE_CLAMP, 1, 10, 1, 1);
        add_row(KIND_SPREAD, 50, 0, 10, 0, 1, 1, MODE_CLAMP, 1, 10, 1, 1);
        add_row(KIND_ROW, VMAX, 0, 0, VMIN, 1, 1, MODE_CLAMP, 1, VMAX, 0, 0);
        add_row(KIND_ROW, 20, 0, 10, 0, 0, 1, MODE_CLAMP, 1, 10, 1, 1);
        // saturation upward, then downward
        add_row(KIND_SPREAD, VMAX - 1, VMIN, VMAX, 0, 0, 0, MODE_CLAMP, 0, 0, 0, 0);
        add_row(KIND_ROW, VMAX, VMIN, 0, 0, 1, 0, MODE_CLAMP, 0, 0, 0, 0);
        add_row(KIND_ROW, VMIN, VMIN, VMAX, 0, 0, 1, MODE_CLAMP, 0, 0, 0, 0);
        add_row(KIND_SPREAD, VMIN + 1, VMIN, VMAX, 0, 0, 0, MODE_CLAMP, 0, 0, 0, 0);
        add_row(KIND_SPREAD, VMIN, 0, VMAX, 0, 0, 0, MODE_CLAMP, 0, 0, 0, 0);
        add_row(KIND_SPREAD, 5, 5, 5, 0, 0, 1, MODE_CLAMP, 0, 0, 0, 0);
        // transition rows: one diagonal, then two
        add_row(KIND_ROW, 32'h5000_0000, 0, 32'h4000_0000, 0, 0, 0, MODE_CLAMP, 0, 0, 0, 0);
        add_row(KIND_ROW, 32'h1000_0000, 0, 1, 0, 1, 0, MODE_CLAMP, 0, 0, 0, 0);
        add_row(KIND_ROW, -1, 0, 32'h100, 0, 0, 0, MODE_CLAMP, 0, 0, 0, 0);
        add_row(KIND_ROW, 7, 0, 32'h100, 0, 0, 1, MODE_CLAMP, 0, 0, 0, 0);
        add_row(KIND_ROW, 1, 0, 0, 0, 1, 0, MODE_CLAMP, 0, 0, 0, 0);
        add_row(KIND_SPREAD, 100, 0, 10, 0, 0, 0, MODE_CLAMP, 0, 0, 0, 0);
        add_row(KIND_SPREAD, 2, 0, 0, 0, 1, 1, MODE_CLAMP, 0, 0, 0, 0);
        // revert mode
        add_row(KIND_SPREAD, 20, 0, 10, -7, 0, 1, MODE_REVERT, 1, -7, 1, 1);
        add_row(KIND_ROW, 20, 0, 10, 20, 0, 1, MODE_REVERT, 1, 20, 1, 0);
        add_row(KIND_SPREAD, VMAX, 0, 0, VMIN, 0, 0, MODE_REVERT, 0, 0, 0, 0);
        add_row(KIND_SPREAD, 0, -1, 1, VMAX, 0, 0, MODE_REVERT, 0, 0, 0, 0);
        add_row(KIND_SPREAD, VMIN, 0, 0, 0, 0, 1, MODE_REVERT, 0, 0, 0, 0);

        for (i = 0; i < dir_rows.size(); i++)
        begin
            if (vec_count == 0 && dir_rows[i].mode != repair_mode_q)
            begin
                drain();
                write_mode(dir_rows[i].mode);
            end
            send_item(dir_rows[i].el, 0, dir_rows[i].typed, dir_rows[i].want);
        end

        for (phase = 0; phase < 4; phase++)
        begin
            pct = (phase == 1) ? 52 : (phase == 3) ? 25 : 0;
            drain();
            write_mode(phase[0] ? MODE_REVERT : MODE_CLAMP);
            phase_items = 0;
            if (phase == 2)
            begin
                send_vector(ML, 1'b1, pct);
                phase_items = ML;
            end
            while (phase_items < 6)
            begin
                i = ($urandom_range(7) == 0) ? 8 : $urandom_range(6, 1);
                send_vector(i, 1'b0, pct);
                phase_items += i;
            end
        end

        drain();
        repeat (120) @(posedge clk);
        if (pending_beats.size() != 0)
        begin
            $display("%0d beats never arrived", pending_beats.size());
            mismatches += pending_beats.size();
        end
        $display("%0d elements in %0d vectors sent, %0d beats checked, clamp and revert modes",
                 items_sent, vectors_closed, beats_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
